// ----- hw/rtl/mdm_pkg.sv -----
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared types, constants and codes of the mecanum drive mixer.
// ----------------------------------------------------------------------------
package mdm_pkg;

    localparam int STICK_FULL   = 650;
    localparam int ROOT_STEPS   = 11;
    localparam int CNT_W        = 5;
    localparam int LANES        = 3;
    localparam int MOVE_LANES   = 2;

    // floor(x / 650) == (x * RECIP_650) >> RECIP_SHIFT for every x below 2**26
    localparam logic [25:0] RECIP_650   = 26'd52861136;
    localparam int          RECIP_SHIFT = 35;

    localparam int IN_DATA_W    = 88;
    localparam int OUT_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MOVE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ROTATE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUSE_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUSE_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_YAW_FWD     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_YAW_BACK    = 3'd6;

    localparam logic [14:0] RST_MAX_MOVE    = 15'd8000;
    localparam logic [14:0] RST_MAX_ROTATE  = 15'd8000;
    localparam logic [7:0]  RST_MOUSE_GAIN  = 8'd10;
    localparam logic [14:0] RST_MOUSE_LIMIT = 15'd8000;
    localparam logic [3:0]  RST_SPEED_GAIN  = 4'd1;
    localparam logic [31:0] RST_YAW_FWD     = 32'd0;
    localparam logic [31:0] RST_YAW_BACK    = 32'd1;

    typedef struct packed {
        logic [14:0] max_move;
        logic [14:0] max_rotate;
        logic [7:0]  mouse_gain;
        logic [14:0] mouse_limit;
        logic [3:0]  speed_gain;
        logic [31:0] yaw_fwd;
        logic [31:0] yaw_back;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic square;
        logic root_step;
        logic mul1;
        logic recip;
        logic split;
        logic scale;
        logic acc;
        logic mix;
        logic write;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_MUL1,
        ST_RECIP1,
        ST_SPLIT,
        ST_SCALE,
        ST_RECIP2,
        ST_ACC,
        ST_RECIP3,
        ST_MIX,
        ST_WRITE
    } state_t;

endpackage

// ----- hw/rtl/mdm_cfg.sv -----
// ----------------------------------------------------------------------------
// mdm_cfg
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mdm_cfg
    import mdm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_move    <= RST_MAX_MOVE;
            cfg_reg.max_rotate  <= RST_MAX_ROTATE;
            cfg_reg.mouse_gain  <= RST_MOUSE_GAIN;
            cfg_reg.mouse_limit <= RST_MOUSE_LIMIT;
            cfg_reg.speed_gain  <= RST_SPEED_GAIN;
            cfg_reg.yaw_fwd     <= RST_YAW_FWD;
            cfg_reg.yaw_back    <= RST_YAW_BACK;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MAX_MOVE:    cfg_reg.max_move    <= wr_data[14:0];
                CFG_MAX_ROTATE:  cfg_reg.max_rotate  <= wr_data[14:0];
                CFG_MOUSE_GAIN:  cfg_reg.mouse_gain  <= wr_data[7:0];
                CFG_MOUSE_LIMIT: cfg_reg.mouse_limit <= wr_data[14:0];
                CFG_SPEED_GAIN:  cfg_reg.speed_gain  <= wr_data[3:0];
                CFG_YAW_FWD:     cfg_reg.yaw_fwd     <= wr_data;
                CFG_YAW_BACK:    cfg_reg.yaw_back    <= wr_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/mdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mdm_ctrl
// Sequencer: steps one sample through square, root, multiply, divide, mix.
// ----------------------------------------------------------------------------
module mdm_ctrl
    import mdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_RECIP1;
            end
            ST_RECIP1:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_RECIP2;
            end
            ST_RECIP2:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_RECIP3;
            end
            ST_RECIP3:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the output beat slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.write;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/mdm_dpath.sv -----
// ----------------------------------------------------------------------------
// mdm_dpath
// Datapath: integer root, stick products, reciprocal division by 650, mix.
// ----------------------------------------------------------------------------
module mdm_dpath
    import mdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  cfg_t                  cfg,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_user,
    output logic [OUT_DATA_W-1:0] out_data
);

    function automatic logic signed [15:0] sat_quo(input logic [16:0] q, input logic neg);
        logic signed [15:0] v;
        if (neg)
            v = (q > 17'd32768) ? 16'sh8000 : 16'(-q);
        else
            v = (q > 17'd32767) ? 16'sh7fff : q[15:0];
        return v;
    endfunction

    function automatic logic signed [15:0] sat_wheel(input logic signed [22:0] v);
        logic signed [15:0] r;
        if (v > 23'sd32767)
            r = 16'sh7fff;
        else if (v < -23'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic signed [10:0] s_reg, f_reg, r_reg;
    logic signed [15:0] mx_reg;
    logic               hold_reg;
    logic [31:0]        yaw_reg;

    logic [21:0]        rad_reg;
    logic [12:0]        rem_reg;
    logic [10:0]        root_reg;

    logic signed [23:0] pm_reg;

    // magnitudes: x is the dividend, q the quotient of one division by 650
    logic [25:0]        x_reg     [LANES];
    logic [16:0]        q_reg     [LANES];
    logic               neg_reg   [LANES];
    logic [9:0]         frac_reg  [MOVE_LANES];
    logic [24:0]        whole_reg [MOVE_LANES];

    logic signed [16:0] vx_reg, vy_reg;
    logic signed [15:0] vr_reg;
    logic               upd_reg;

    logic signed [15:0] held_reg;
    logic signed [15:0] wheel_reg [4];

    logic [10:0]        abs_s, abs_f, abs_r;
    logic [14:0]        rem_sh, trial;
    logic               root_ge;
    logic [9:0]         m_clamp;
    logic [19:0]        mag_s, mag_f;
    logic [51:0]        recip_prod [LANES];
    logic [9:0]         split_rem  [MOVE_LANES];
    logic signed [15:0] vx_new, vy_new, vy_use, vr_new;
    logic signed [24:0] pm_ext, lim_ext;
    logic               fwd, back;
    logic signed [18:0] vx_e, vy_e, vr_e;
    logic signed [18:0] sum [4];
    logic signed [22:0] prod [4];

    always_comb
    begin
        abs_s   = s_reg[10] ? 11'(-s_reg) : 11'(s_reg);
        abs_f   = f_reg[10] ? 11'(-f_reg) : 11'(f_reg);
        abs_r   = r_reg[10] ? 11'(-r_reg) : 11'(r_reg);
        rem_sh  = {rem_reg, rad_reg[21:20]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = rem_sh >= trial;
        m_clamp = (root_reg > 11'(STICK_FULL)) ? 10'(STICK_FULL) : root_reg[9:0];
        mag_s   = 20'(abs_s * m_clamp);
        mag_f   = 20'(abs_f * m_clamp);

        for (int i = 0; i < LANES; i++)
            recip_prod[i] = 52'(x_reg[i] * RECIP_650);
        for (int i = 0; i < MOVE_LANES; i++)
            split_rem[i] = 10'(x_reg[i][19:0] - 20'(q_reg[i][10:0] * 10'(STICK_FULL)));

        vx_new  = sat_quo(q_reg[0], neg_reg[0]);
        vy_new  = sat_quo(q_reg[1], neg_reg[1]);
        vy_use  = hold_reg ? held_reg : vy_new;
        pm_ext  = {pm_reg[23], pm_reg};
        lim_ext = {10'd0, cfg.mouse_limit};
        if (mx_reg == 16'sd0)
            vr_new = sat_quo(q_reg[2], neg_reg[2]);
        else if (pm_ext > lim_ext)
            vr_new = 16'(lim_ext);
        else if (pm_ext < -lim_ext)
            vr_new = 16'(-lim_ext);
        else
            vr_new = pm_reg[15:0];
        fwd  = yaw_reg == cfg.yaw_fwd;
        back = yaw_reg == cfg.yaw_back;

        vx_e   = {{2{vx_reg[16]}}, vx_reg};
        vy_e   = {{2{vy_reg[16]}}, vy_reg};
        vr_e   = {{3{vr_reg[15]}}, vr_reg};
        sum[0] = -vy_e + vx_e + vr_e;
        sum[1] =  vy_e + vx_e + vr_e;
        sum[2] =  vy_e - vx_e + vr_e;
        sum[3] = -vy_e - vx_e + vr_e;
        for (int i = 0; i < 4; i++)
            prod[i] = 23'(sum[i] * $signed({1'b0, cfg.speed_gain}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg    <= in_data[10:0];
            f_reg    <= in_data[21:11];
            r_reg    <= in_data[32:22];
            mx_reg   <= in_data[48:33];
            yaw_reg  <= in_data[80:49];
            hold_reg <= in_user;
        end
        if (cmd.square)
        begin
            rad_reg  <= 22'(abs_s * abs_s) + 22'(abs_f * abs_f);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[19:0], 2'b00};
            rem_reg  <= root_ge ? 13'(rem_sh - trial) : rem_sh[12:0];
            root_reg <= {root_reg[9:0], root_ge};
        end
        if (cmd.mul1)
        begin
            x_reg[0]   <= 26'(mag_s);
            x_reg[1]   <= 26'(mag_f);
            x_reg[2]   <= 26'(abs_r * cfg.max_rotate);
            neg_reg[0] <= s_reg[10];
            neg_reg[1] <= f_reg[10];
            neg_reg[2] <= r_reg[10];
            pm_reg     <= 24'($signed(mx_reg) * $signed({1'b0, cfg.mouse_gain}));
        end
        if (cmd.recip)
        begin
            for (int i = 0; i < LANES; i++)
                q_reg[i] <= recip_prod[i][RECIP_SHIFT+16:RECIP_SHIFT];
        end
        // a*mm / 650^2 == (a1*mm + (a0*mm) / 650) / 650 with a = 650*a1 + a0
        for (int i = 0; i < MOVE_LANES; i++)
        begin
            if (cmd.split)
                frac_reg[i] <= split_rem[i];
            if (cmd.scale)
            begin
                whole_reg[i] <= 25'(q_reg[i][10:0] * cfg.max_move);
                x_reg[i]     <= 26'(frac_reg[i] * cfg.max_move);
            end
            if (cmd.acc)
                x_reg[i] <= 26'(whole_reg[i]) + 26'(q_reg[i]);
        end
        if (cmd.mix)
        begin
            // back view turns the translation round
            vx_reg  <= fwd ? 17'(vx_new) : -17'(vx_new);
            vy_reg  <= fwd ? 17'(vy_use) : -17'(vy_use);
            vr_reg  <= vr_new;
            upd_reg <= fwd || back;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            for (int i = 0; i < 4; i++)
                wheel_reg[i] <= '0;
        end
        else
        begin
            if (cmd.mix && !hold_reg)
                held_reg <= vy_new;
            if (cmd.write && upd_reg)
            begin
                for (int i = 0; i < 4; i++)
                    wheel_reg[i] <= sat_wheel(prod[i]);
            end
        end
    end

    assign out_data = {wheel_reg[3], wheel_reg[2], wheel_reg[1], wheel_reg[0]};

endmodule

// ----- hw/rtl/mecanum_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// mecanum_drive_mixer
// Turns one stick and mouse sample into four mecanum wheel speed targets.
//
// Channel   Direction  Beat carries
// s_axis    in         strafe, forward, rotate, mouse_x, yaw; tuser hold_forward
// m_axis    out        right front, left front, left back, right back wheel
// cfg       in         register index and write data
//
// A sample passes from accept to result through 11 root steps, the stick
// products, and three reciprocal divisions by 650 with split, scale and add
// steps between them, then the mix and the write.
// One sample is in work at a time; the next is taken only once the result
// has entered the output register. A result still waiting on m_axis_tready
// holds the next one in its write step.
// Reset loads the register defaults and clears held speed and wheel targets.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer
    import mdm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // strafe[10:0], forward[21:11], rotate[32:22], mouse_x[48:33], yaw[80:49]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // hold_forward[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // right_front[15:0], left_front[31:16], left_back[47:32], right_back[63:48]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    mdm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    mdm_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .out_data (m_axis_tdata)
    );

endmodule

// ----- tb/sv/tb_mecanum_drive_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mecanum_drive_mixer
// Self-checking bench for the mecanum drive mixer. Stick and mouse samples
// are streamed in, each expected set of wheel targets is worked out by an
// integer model of the mixer and compared field by field with the output
// beats. Runs through reset, extreme and random register settings, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_mecanum_drive_mixer;
    import mdm_pkg::*;

    localparam longint STICK_RANGE = 650;
    localparam longint MOVE_DIV    = STICK_RANGE * STICK_RANGE;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     SHOWN_MAX   = 30;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic signed [10:0] strafe;
        logic signed [10:0] forward;
        logic signed [10:0] rotate;
        logic signed [15:0] mouse_x;
        logic               hold;
        logic signed [31:0] yaw;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] rb;
        logic signed [15:0] lb;
        logic signed [15:0] lf;
        logic signed [15:0] rf;
    } wheels_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_t cfg_m = '{max_move: RST_MAX_MOVE, max_rotate: RST_MAX_ROTATE,
                    mouse_gain: RST_MOUSE_GAIN, mouse_limit: RST_MOUSE_LIMIT,
                    speed_gain: RST_SPEED_GAIN, yaw_fwd: RST_YAW_FWD,
                    yaw_back: RST_YAW_BACK};
    logic signed [15:0] held_fwd_speed = '0;
    wheels_t            wheel_now = '0;

    sample_t sample_q[$];
    sample_t cur_sample;
    wheels_t wheel_exp_q[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_queued      = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_fwd_view    = 0;
    int n_back_view   = 0;
    int n_other_view  = 0;
    int n_mouse       = 0;
    int n_hold        = 0;
    int n_errors      = 0;
    int cycles        = 0;

    mecanum_drive_mixer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic longint root_floor(input longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 11; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Advance the mixer model by one sample and return the wheel targets.
    function automatic wheels_t mix_sample(input sample_t smp);
        longint s, f, r, mx, m, vx, vy, vr, lim, mm, sg;
        s  = smp.strafe;
        f  = smp.forward;
        r  = smp.rotate;
        mx = smp.mouse_x;
        mm = longint'(cfg_m.max_move);
        sg = longint'(cfg_m.speed_gain);

        m = root_floor(s * s + f * f);
        if (m > STICK_RANGE)
            m = STICK_RANGE;
        vx = sat16(s * m * mm / MOVE_DIV);
        if (!smp.hold)
            held_fwd_speed = sat16(f * m * mm / MOVE_DIV);
        else
            n_hold++;
        vy = held_fwd_speed;

        vr = sat16(r * longint'(cfg_m.max_rotate) / STICK_RANGE);
        if (mx != 0)
        begin
            n_mouse++;
            lim = longint'(cfg_m.mouse_limit);
            vr  = mx * longint'(cfg_m.mouse_gain);
            if (vr > lim)
                vr = lim;
            if (vr < -lim)
                vr = -lim;
        end

        if (smp.yaw == cfg_m.yaw_fwd || smp.yaw == cfg_m.yaw_back)
        begin
            if (smp.yaw != cfg_m.yaw_fwd)
            begin
                vx = -vx;
                vy = -vy;
                n_back_view++;
            end
            else
                n_fwd_view++;
            wheel_now.rf = sat16((-vy + vx + vr) * sg);
            wheel_now.lf = sat16((vy + vx + vr) * sg);
            wheel_now.lb = sat16((vy - vx + vr) * sg);
            wheel_now.rb = sat16((-vy - vx + vr) * sg);
        end
        else
            n_other_view++;
        return wheel_now;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_MAX_MOVE:    cfg_m.max_move    = value[14:0];
            CFG_MAX_ROTATE:  cfg_m.max_rotate  = value[14:0];
            CFG_MOUSE_GAIN:  cfg_m.mouse_gain  = value[7:0];
            CFG_MOUSE_LIMIT: cfg_m.mouse_limit = value[14:0];
            CFG_SPEED_GAIN:  cfg_m.speed_gain  = value[3:0];
            CFG_YAW_FWD:     cfg_m.yaw_fwd     = value;
            CFG_YAW_BACK:    cfg_m.yaw_back    = value;
            default:         ;
        endcase
    endfunction

    task automatic report(input string msg);
        if (n_errors < SHOWN_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    // Input side: present queued samples, predict on every accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                wheel_exp_q.push_back(mix_sample(cur_sample));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_sample = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({cur_sample.yaw, cur_sample.mouse_x,
                                                 cur_sample.rotate, cur_sample.forward,
                                                 cur_sample.strafe});
                    s_axis_tuser  <= cur_sample.hold;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure and field-by-field check.
    always @(posedge clk)
    begin
        wheels_t got;
        wheels_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                n_results++;
                if (wheel_exp_q.size() == 0)
                    report($sformatf("result beat %h with nothing outstanding", got));
                else
                begin
                    want = wheel_exp_q.pop_front();
                    if (got.rf !== want.rf)
                        report($sformatf("right front %0d, want %0d", got.rf, want.rf));
                    if (got.lf !== want.lf)
                        report($sformatf("left front %0d, want %0d", got.lf, want.lf));
                    if (got.lb !== want.lb)
                        report($sformatf("left back %0d, want %0d", got.lb, want.lb));
                    if (got.rb !== want.rb)
                        report($sformatf("right back %0d, want %0d", got.rb, want.rb));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic sample_t stick_sample(input int s, input int f, input int r,
                                             input int mx, input bit h,
                                             input logic [31:0] yaw);
        sample_t smp;
        smp.strafe  = 11'(s);
        smp.forward = 11'(f);
        smp.rotate  = 11'(r);
        smp.mouse_x = 16'(mx);
        smp.hold    = h;
        smp.yaw     = yaw;
        return smp;
    endfunction

    function automatic logic signed [10:0] rand_stick();
        int v;
        if ($urandom_range(0, 4) == 0)
            return 11'($urandom);
        v = $urandom_range(0, 1320);
        return 11'(v - 660);
    endfunction

    function automatic sample_t rand_sample();
        sample_t smp;
        int pick;
        int v;
        smp.strafe  = rand_stick();
        smp.forward = rand_stick();
        smp.rotate  = rand_stick();
        smp.hold    = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            smp.mouse_x = '0;
        else if (pick < 7)
            smp.mouse_x = 16'($urandom);
        else
        begin
            v = $urandom_range(0, 400);
            smp.mouse_x = 16'(v - 200);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
            smp.yaw = cfg_m.yaw_fwd;
        else if (pick < 80)
            smp.yaw = cfg_m.yaw_back;
        else
            smp.yaw = $urandom;
        return smp;
    endfunction

    task automatic queue_sample(input sample_t smp);
        sample_q.push_back(smp);
        n_queued++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_sample(rand_sample());
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || wheel_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper bits carry junk; the block must drop them.
    task automatic set_config(input int mm, input int mr, input int mg, input int ml,
                              input int sg, input logic [31:0] yf, input logic [31:0] yb);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_MAX_MOVE,    {junk[31:15], 15'(mm)});
        write_reg(CFG_MAX_ROTATE,  {junk[30:14], 15'(mr)});
        write_reg(CFG_MOUSE_GAIN,  {junk[29:6],  8'(mg)});
        write_reg(CFG_MOUSE_LIMIT, {junk[28:12], 15'(ml)});
        write_reg(CFG_SPEED_GAIN,  {junk[27:0],  4'(sg)});
        write_reg(CFG_YAW_FWD,     yf);
        write_reg(CFG_YAW_BACK,    yb);
    endtask

    initial
    begin
        logic [31:0] yaw_shared;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, no idling
        queue_sample(stick_sample(0, 0, 0, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(660, 0, 0, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(0, 660, 0, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(0, 0, 0, 0, 1, RST_YAW_FWD));
        queue_sample(stick_sample(200, -300, 100, 0, 1, RST_YAW_BACK));
        queue_sample(stick_sample(-1024, -1024, -1024, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(1023, 1023, 1023, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(1023, -1024, 0, 0, 0, RST_YAW_BACK));
        queue_sample(stick_sample(0, 0, 660, 1, 0, RST_YAW_FWD));
        queue_sample(stick_sample(0, 0, -660, -1, 0, RST_YAW_BACK));
        queue_sample(stick_sample(0, 0, 0, 32767, 0, RST_YAW_FWD));
        queue_sample(stick_sample(0, 0, 0, -32768, 0, RST_YAW_FWD));
        queue_sample(stick_sample(500, 500, 500, 0, 0, 32'h7fffffff));
        queue_sample(stick_sample(-500, 300, 0, 77, 1, 32'h80000000));
        queue_sample(stick_sample(-660, 660, -660, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(467, 467, 0, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(459, 459, 0, 0, 0, RST_YAW_FWD));
        queue_sample(stick_sample(-3, 4, 1, 0, 0, 32'hffffffff));
        queue_sample(stick_sample(-660, -660, 1023, 0, 0, RST_YAW_BACK));
        queue_sample(stick_sample(0, -1, 0, 0, 0, RST_YAW_BACK));
        wait_drained();

        // random settings within range; sender holds off mid-way
        set_config($urandom_range(0, 16384), $urandom_range(0, 16384),
                   $urandom_range(0, 255), $urandom_range(0, 16384),
                   $urandom_range(1, 15), $urandom, $urandom);
        queue_random(112);
        wait_drained();
        queue_random(113);
        wait_drained();

        // top of every register, sender idling
        set_config(32767, 32767, 255, 32767, 15, 32'h7fffffff, 32'h80000000);
        send_idle_pct = 79;
        queue_random(225);
        wait_drained();

        // bottom of the move and mouse registers, both yaw codes equal,
        // receiver stalling
        yaw_shared = $urandom;
        set_config(0, 16384, 0, 0, 15, yaw_shared, yaw_shared);
        send_idle_pct = 0;
        stall_pct     = 79;
        queue_random(100);
        wait_drained();

        // unknown index dropped; both sides idling
        write_reg(CFG_UNUSED, $urandom);
        set_config(16384, 0, 255, 16384, 2, $urandom, $urandom);
        send_idle_pct = 22;
        stall_pct     = 22;
        queue_random(225);
        wait_drained();

        // zero speed gain, no idling
        set_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 255), $urandom_range(0, 32767), 0,
                   $urandom, $urandom);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random(125);
        wait_drained();

        repeat (40) @(posedge clk);

        $display("covered %0d samples, %0d results: %0d forward view, %0d back view, %0d held",
                 n_accepted, n_results, n_fwd_view, n_back_view, n_other_view);
        $display("  %0d mouse-driven rotations, %0d with forward speed kept; %0d mismatches",
                 n_mouse, n_hold, n_errors);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- mecanum_drive_mixer.f -----
hw/rtl/mdm_pkg.sv
hw/rtl/mdm_cfg.sv
hw/rtl/mdm_ctrl.sv
hw/rtl/mdm_dpath.sv
hw/rtl/mecanum_drive_mixer.sv
tb/sv/tb_mecanum_drive_mixer.sv
